### src/deq_pkg.sv
// deq_pkg: shared types and constants for the double-ended queue.
// Command codes, beat payload structs and the per-cell control struct.
// No dependencies.
package deq_pkg;

	localparam int unsigned DEQ_DEPTH = 16;

	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	localparam logic signed [31:0] EMPTY_POP_VALUE = -32'sd1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] push_value;
	} deq_req_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic               empty_error;
		logic               full_error;
		logic               now_empty;
	} deq_rsp_t;

	// broadcast to every cell; at most one bit set, only on an accepted beat
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_op_t;

endpackage

### src/deq_stream_if.sv
// deq_stream_if: valid/ready channel carrying one payload struct per beat.
// Payload type comes in as a parameter; used with deq_pkg structs.
interface deq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/deq_cell.sv
// deq_cell: one slot of the queue chain plus one stage of the return lane.
// Depends on deq_pkg (cell_op_t).
module deq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  deq_pkg::cell_op_t    op,
	input  logic                 sel_free,
	input  logic                 sel_tail,
	input  logic signed [31:0]   push_value,
	input  logic signed [31:0]   prev_data,
	input  logic signed [31:0]   next_data,
	input  logic signed [31:0]   next_ret_data,
	input  logic                 next_ret_valid,
	output logic signed [31:0]   data,
	output logic signed [31:0]   ret_data,
	output logic                 ret_valid
);
	logic signed [31:0] data_q;
	logic signed [31:0] ret_data_q;
	logic               ret_valid_q;
	logic               take_tail;

	assign take_tail = op.pop_back && sel_tail;

	// slot contents: shift toward the back, toward the front, or fill at the back
	always_ff @(posedge clk) begin
		if (op.push_front) begin
			data_q <= prev_data;
		end else if (op.pop_front) begin
			data_q <= next_data;
		end else if (op.push_back && sel_free) begin
			data_q <= push_value;
		end
	end

	// return lane: a popped back entry walks toward cell 0
	always_ff @(posedge clk) begin
		ret_data_q <= take_tail ? data_q : next_ret_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_valid_q <= 1'b0;
		end else begin
			ret_valid_q <= take_tail || next_ret_valid;
		end
	end

	assign data      = data_q;
	assign ret_data  = ret_data_q;
	assign ret_valid = ret_valid_q;
endmodule

### src/double_ended_queue.sv
// double_ended_queue: bounded deque of signed 32-bit values as a chain of cells.
// Depends on deq_pkg, deq_stream_if and deq_cell.
//
// Usage:
//   req carries one command per beat: cmd (push front, push back, pop front,
//   pop back) and push_value. rsp returns exactly one beat per command with
//   pop_value, empty_error, full_error and now_empty.
//   Cell 0 always holds the front entry; cell k holds the k-th entry.
//   Push front shifts the whole row one cell back, pop front one cell forward,
//   push back writes the first free cell. Pop back lifts the tail cell into a
//   return lane that moves one cell toward cell 0 per clock.
// Results:
//   push, pop front and any error beat: result in the output register in
//   the cycle after the command beat. Pop back: the tail entry walks the
//   return lane to cell 0, then to rsp. One command is in flight at a time.
// Reset:
//   arst_n empties the queue (entry count to zero) and drops any result
//   waiting on rsp. Slot contents are not cleared.
// Stall:
//   rsp holds its beat while ready is low; req is taken only in ST_IDLE and
//   when the output register is free or being emptied in the same cycle.
module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	deq_stream_if.sink    req,
	deq_stream_if.source  rsp
);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;  // ready for a command
	localparam logic ST_RET  = 1'b1;  // waiting on the return lane

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic              rsp_valid_q;
	deq_pkg::deq_rsp_t rsp_data_q;
	deq_pkg::deq_rsp_t rsp_now;

	logic              q_full;
	logic              q_empty;
	logic              out_free;
	logic              acc;
	logic              wait_ret;
	deq_pkg::cell_op_t op;

	logic signed [31:0] data_w     [DEPTH];
	logic signed [31:0] ret_data_w [DEPTH];
	logic               ret_valid_w[DEPTH];

	assign q_full   = (count_q == CW'(DEPTH));
	assign q_empty  = (count_q == '0);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign acc      = req.valid && req.ready;

	// decode the accepted command into a cell operation and the new count
	always_comb begin
		op        = '0;
		count_nxt = count_q;
		wait_ret  = 1'b0;
		rsp_now   = '0;
		case (req.data.cmd)
			deq_pkg::CMD_PUSH_FRONT: begin
				op.push_front      = acc && !q_full;
				rsp_now.full_error = q_full;
				if (!q_full) begin
					count_nxt = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				op.push_back       = acc && !q_full;
				rsp_now.full_error = q_full;
				if (!q_full) begin
					count_nxt = count_q + CW'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				op.pop_front        = acc && !q_empty;
				rsp_now.empty_error = q_empty;
				if (q_empty) begin
					rsp_now.pop_value = deq_pkg::EMPTY_POP_VALUE;
				end else begin
					rsp_now.pop_value = data_w[0];
					count_nxt         = count_q - CW'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				op.pop_back         = acc && !q_empty;
				rsp_now.empty_error = q_empty;
				if (q_empty) begin
					rsp_now.pop_value = deq_pkg::EMPTY_POP_VALUE;
				end else begin
					count_nxt = count_q - CW'(1);
					wait_ret  = 1'b1;
				end
			end
			default: begin
				op = '0;
			end
		endcase
		rsp_now.now_empty = (count_nxt == '0);
	end

	// control: count, state and the output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && wait_ret) begin
						state_q <= ST_RET;
					end
				end
				ST_RET: begin
					if (ret_valid_w[0]) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((acc && !wait_ret) || (state_q == ST_RET && ret_valid_w[0])) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output payload; the return lane result has both error flags clear
	always_ff @(posedge clk) begin
		if (acc && !wait_ret) begin
			rsp_data_q <= rsp_now;
		end else if (state_q == ST_RET && ret_valid_w[0]) begin
			rsp_data_q.pop_value   <= ret_data_w[0];
			rsp_data_q.empty_error <= 1'b0;
			rsp_data_q.full_error  <= 1'b0;
			rsp_data_q.now_empty   <= q_empty;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// the row of cells; neighbours wired at fixed places
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] prev_d;
		logic signed [31:0] next_d;
		logic signed [31:0] next_rd;
		logic               next_rv;

		if (i == 0) begin : g_head
			assign prev_d = req.data.push_value;
		end else begin : g_body
			assign prev_d = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d  = '0;
			assign next_rd = '0;
			assign next_rv = 1'b0;
		end else begin : g_inner
			assign next_d  = data_w[i+1];
			assign next_rd = ret_data_w[i+1];
			assign next_rv = ret_valid_w[i+1];
		end

		deq_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.op             (op),
			.sel_free       (count_q == CW'(i)),
			.sel_tail       (count_q == CW'(i + 1)),
			.push_value     (req.data.push_value),
			.prev_data      (prev_d),
			.next_data      (next_d),
			.next_ret_data  (next_rd),
			.next_ret_valid (next_rv),
			.data           (data_w[i]),
			.ret_data       (ret_data_w[i]),
			.ret_valid      (ret_valid_w[i])
		);
	end
endmodule
